// File: src/mlem_intensity_estimator_top_assert.svh
// Assertion macros for the MLEM intensity estimator
`ifndef MLEM_INTENSITY_ESTIMATOR_TOP_ASSERT_SVH
`define MLEM_INTENSITY_ESTIMATOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define MLEM_ASSERT_IMP(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("implication check failed");
`define MLEM_ASSERT_NXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("next-cycle check failed");
`else
`define MLEM_ASSERT_IMP(label, clk, rst_n, a, b)
`define MLEM_ASSERT_NXT(label, clk, rst_n, a, b)
`endif
`endif

// File: src/mlem_pkg.sv
// Shared constants and types for the MLEM intensity estimator
package mlem_pkg;
	localparam int DEF_MAX_SOURCES   = 64;
	localparam int DEF_MAX_DETECTORS = 256;
	localparam int DEF_FRAC_BITS     = 16;

	localparam logic [1:0] ACT_EFF = 2'd0;
	localparam logic [1:0] ACT_CNT = 2'd1;
	localparam logic [1:0] ACT_RUN = 2'd2;

	localparam logic [1:0] CFG_ITER  = 2'd0;
	localparam logic [1:0] CFG_NSRC  = 2'd1;
	localparam logic [1:0] CFG_NDET  = 2'd2;
	localparam logic [1:0] CFG_INIT  = 2'd3;

	typedef struct packed {
		logic        start;
		logic [63:0] num_hi;
		logic [63:0] num_lo;
		logic [63:0] den;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] quo;
	} div_rsp_t;
endpackage

// File: src/mlem_div.sv
// Iterative 128-by-64 divider, one quotient bit per cycle, saturating
module mlem_div (
	input  logic              clk,
	input  logic              arst_n,
	input  mlem_pkg::div_req_t req,
	output mlem_pkg::div_rsp_t rsp
);
	import mlem_pkg::*;

	logic        run_q, done_q;
	logic [5:0]  cnt_q;
	logic [63:0] rem_q, lo_q, den_q, quo_q;
	logic [63:0] rem_sh;
	logic        take;

	assign rem_sh = {rem_q[62:0], lo_q[63]};
	assign take   = rem_q[63] || (rem_sh >= den_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= '0;
				if (req.den == 64'd0 || req.num_hi >= req.den) begin
					done_q <= 1'b1;
				end else begin
					run_q <= 1'b1;
				end
			end else if (run_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num_hi;
			lo_q  <= req.num_lo;
			den_q <= req.den;
			if (req.den == 64'd0) begin
				quo_q <= '0;
			end else if (req.num_hi >= req.den) begin
				quo_q <= '1;
			end else begin
				quo_q <= '0;
			end
		end else if (run_q) begin
			lo_q  <= {lo_q[62:0], 1'b0};
			rem_q <= take ? rem_sh - den_q : rem_sh;
			quo_q <= {quo_q[62:0], take};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
endmodule

// File: src/mlem_store.sv
// Efficiency and detector count memories, written by load words
module mlem_store #(
	parameter int MAX_SOURCES   = mlem_pkg::DEF_MAX_SOURCES,
	parameter int MAX_DETECTORS = mlem_pkg::DEF_MAX_DETECTORS,
	localparam int SRC_W = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1,
	localparam int DET_W = (MAX_DETECTORS > 1) ? $clog2(MAX_DETECTORS) : 1
) (
	input  logic             clk,
	input  logic             eff_we,
	input  logic             cnt_we,
	input  logic [DET_W-1:0] wr_det,
	input  logic [SRC_W-1:0] wr_src,
	input  logic [31:0]      wr_data,
	input  logic [DET_W-1:0] rd_det,
	input  logic [SRC_W-1:0] rd_src,
	output logic [23:0]      eff_rd,
	output logic [31:0]      cnt_rd
);
	import mlem_pkg::*;

	logic [23:0] eff_mem [2**(DET_W+SRC_W)];
	logic [31:0] cnt_mem [2**DET_W];

	always_ff @(posedge clk) begin
		if (eff_we) begin
			eff_mem[{wr_det, wr_src}] <= wr_data[23:0];
		end
		eff_rd <= eff_mem[{rd_det, rd_src}];
	end

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[wr_det] <= wr_data;
		end
		cnt_rd <= cnt_mem[rd_det];
	end
endmodule

// File: src/mlem_core.sv
// Run sequencer: sensitivity, forward and back projection, update, readout
module mlem_core #(
	parameter int MAX_SOURCES         = mlem_pkg::DEF_MAX_SOURCES,
	parameter int MAX_DETECTORS       = mlem_pkg::DEF_MAX_DETECTORS,
	parameter int INTENSITY_FRAC_BITS = mlem_pkg::DEF_FRAC_BITS,
	localparam int SRC_W = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1,
	localparam int DET_W = (MAX_DETECTORS > 1) ? $clog2(MAX_DETECTORS) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             run,
	input  logic [DET_W-1:0] nd_m1,
	input  logic [SRC_W-1:0] ns_m1,
	input  logic [9:0]       iter_count,
	input  logic [39:0]      init_int,
	input  logic [23:0]      eff_rd,
	input  logic [31:0]      cnt_rd,
	output logic [DET_W-1:0] rd_det,
	output logic [SRC_W-1:0] rd_src,
	output logic             busy,
	output logic             res_strobe,
	output logic [5:0]       res_source,
	output logic [39:0]      res_intensity,
	output logic             res_last
);
	import mlem_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_SENS  = 8'b0000_0010,
		ST_FWD   = 8'b0000_0100,
		ST_RATIO = 8'b0000_1000,
		ST_BACK  = 8'b0001_0000,
		ST_UPD   = 8'b0010_0000,
		ST_UDIV  = 8'b0100_0000,
		ST_EMIT  = 8'b1000_0000
	} state_t;

	localparam logic [2:0] PH_WAIT = 3'd0;
	localparam logic [2:0] PH_LO   = 3'd1;
	localparam logic [2:0] PH_HI   = 3'd2;
	localparam logic [2:0] PH_SUM  = 3'd3;
	localparam logic [2:0] PH_ACC  = 3'd4;

	state_t           state_q;
	logic [2:0]       ph_q;
	logic [DET_W-1:0] det_q;
	logic [SRC_W-1:0] src_q;
	logic             bank_q;
	logic [9:0]       iter_q;
	logic [63:0]      acc_q, back_q;
	logic [71:0]      prod_lo_q, prod_hi_q;
	logic [103:0]     full_q;
	div_req_t         div_req_q;
	div_rsp_t         div_rsp;

	logic [31:0] sens_mem [2**SRC_W];
	logic [39:0] int_mem  [2**(SRC_W+1)];
	logic [63:0] ratio_mem [2**DET_W];
	logic [31:0] sens_rd;
	logic [39:0] int_rd;
	logic [63:0] ratio_rd;

	logic             sens_we, int_we, ratio_we;
	logic [SRC_W:0]   int_wa;
	logic [39:0]      int_wd;
	logic [31:0]      sens_wd;

	logic [39:0]  mul_a;
	logic [63:0]  mul_b;
	logic [63:0]  term, acc_nx;
	logic [64:0]  acc_sum;
	logic         det_last, src_last;

	mlem_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req_q),
		.rsp    (div_rsp)
	);

	assign det_last = (det_q == nd_m1);
	assign src_last = (src_q == ns_m1);
	assign rd_det   = det_q;
	assign rd_src   = src_q;
	assign busy     = (state_q != ST_IDLE);

	always_comb begin
		mul_a = {16'd0, eff_rd};
		mul_b = 64'd1;
		case (state_q)
			ST_FWD:  mul_b = {24'd0, int_rd};
			ST_BACK: mul_b = ratio_rd;
			ST_UPD: begin
				mul_a = int_rd;
				mul_b = back_q;
			end
			default: mul_b = 64'd1;
		endcase
	end

	assign term    = (state_q == ST_BACK) ? full_q[87:24] : full_q[63:0];
	assign acc_sum = {1'b0, acc_q} + {1'b0, term};
	assign acc_nx  = acc_sum[64] ? '1 : acc_sum[63:0];

	// Memory write controls
	always_comb begin
		sens_we  = 1'b0;
		int_we   = 1'b0;
		ratio_we = 1'b0;
		sens_wd  = (acc_nx[63:32] != 32'd0) ? '1 : acc_nx[31:0];
		int_wa   = {bank_q, src_q};
		int_wd   = init_int;
		case (state_q)
			ST_SENS: begin
				if (ph_q == PH_ACC && det_last) begin
					sens_we = 1'b1;
					int_we  = 1'b1;
				end
			end
			ST_RATIO: ratio_we = div_rsp.done;
			ST_UDIV: begin
				int_we = div_rsp.done;
				int_wa = {~bank_q, src_q};
				int_wd = (div_rsp.quo[63:40] != 24'd0) ? '1 : div_rsp.quo[39:0];
			end
			default: int_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (sens_we) begin
			sens_mem[src_q] <= sens_wd;
		end
		sens_rd <= sens_mem[src_q];
	end

	always_ff @(posedge clk) begin
		if (int_we) begin
			int_mem[int_wa] <= int_wd;
		end
		int_rd <= int_mem[{bank_q, src_q}];
	end

	always_ff @(posedge clk) begin
		if (ratio_we) begin
			ratio_mem[det_q] <= div_rsp.quo;
		end
		ratio_rd <= ratio_mem[det_q];
	end

	// Multiply in two 32-bit halves, then merge
	always_ff @(posedge clk) begin
		if (ph_q == PH_LO) begin
			prod_lo_q <= 72'(mul_a) * 72'(mul_b[31:0]);
		end
		if (ph_q == PH_HI) begin
			prod_hi_q <= 72'(mul_a) * 72'(mul_b[63:32]);
		end
		if (ph_q == PH_SUM) begin
			full_q <= {prod_hi_q, 32'd0} + {32'd0, prod_lo_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			ph_q            <= PH_WAIT;
			det_q           <= '0;
			src_q           <= '0;
			bank_q          <= 1'b0;
			iter_q          <= '0;
			acc_q           <= '0;
			back_q          <= '0;
			div_req_q.start <= 1'b0;
			res_strobe      <= 1'b0;
		end else begin
			div_req_q.start <= 1'b0;
			res_strobe      <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (run) begin
						state_q <= ST_SENS;
						ph_q    <= PH_WAIT;
						det_q   <= '0;
						src_q   <= '0;
						acc_q   <= '0;
						iter_q  <= '0;
					end
				end
				ST_SENS, ST_FWD, ST_BACK, ST_UPD: begin
					ph_q <= (ph_q == PH_ACC) ? PH_WAIT : ph_q + 3'd1;
					if (ph_q == PH_ACC) begin
						acc_q <= acc_nx;
						case (state_q)
							ST_SENS: begin
								if (!det_last) begin
									det_q <= det_q + DET_W'(1);
								end else begin
									det_q <= '0;
									acc_q <= '0;
									if (src_last) begin
										src_q   <= '0;
										state_q <= (iter_count == 10'd0) ? ST_EMIT : ST_FWD;
									end else begin
										src_q <= src_q + SRC_W'(1);
									end
								end
							end
							ST_FWD: begin
								if (!src_last) begin
									src_q <= src_q + SRC_W'(1);
								end else begin
									src_q            <= '0;
									acc_q            <= '0;
									div_req_q.start  <= 1'b1;
									div_req_q.num_hi <= 64'(cnt_rd) << (INTENSITY_FRAC_BITS - 8);
									div_req_q.num_lo <= '0;
									div_req_q.den    <= acc_nx;
									state_q          <= ST_RATIO;
								end
							end
							ST_BACK: begin
								if (!det_last) begin
									det_q <= det_q + DET_W'(1);
								end else begin
									det_q   <= '0;
									acc_q   <= '0;
									back_q  <= acc_nx;
									state_q <= ST_UPD;
								end
							end
							default: begin
								acc_q            <= '0;
								div_req_q.start  <= 1'b1;
								div_req_q.num_hi <= {24'd0, full_q[103:64]};
								div_req_q.num_lo <= full_q[63:0];
								div_req_q.den    <= {24'd0, sens_rd, 8'd0};
								state_q          <= ST_UDIV;
							end
						endcase
					end
				end
				ST_RATIO: begin
					if (div_rsp.done) begin
						if (det_last) begin
							det_q   <= '0;
							state_q <= ST_BACK;
						end else begin
							det_q   <= det_q + DET_W'(1);
							state_q <= ST_FWD;
						end
					end
				end
				ST_UDIV: begin
					if (div_rsp.done) begin
						if (src_last) begin
							src_q  <= '0;
							bank_q <= ~bank_q;
							iter_q <= iter_q + 10'd1;
							// advance to next iteration or read out
							if ({1'b0, iter_q} + 11'd1 == {1'b0, iter_count}) begin
								state_q <= ST_EMIT;
							end else begin
								state_q <= ST_FWD;
							end
						end else begin
							src_q   <= src_q + SRC_W'(1);
							state_q <= ST_BACK;
						end
					end
				end
				ST_EMIT: begin
					if (ph_q == PH_WAIT) begin
						ph_q <= PH_LO;
					end else begin
						ph_q       <= PH_WAIT;
						res_strobe <= 1'b1;
						if (src_last) begin
							src_q   <= '0;
							state_q <= ST_IDLE;
						end else begin
							src_q <= src_q + SRC_W'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && ph_q == PH_LO) begin
			res_source    <= 6'(src_q);
			res_intensity <= int_rd;
			res_last      <= src_last;
		end
	end
endmodule

// File: src/mlem_intensity_estimator_top.sv
// A run keeps busy high; its length is set by the shared multiply-accumulate
// and the bit-serial divider. Results cannot be stalled. Reset returns the
// sequencer to idle and the configuration registers to their defaults;
// memories hold no reset value. The efficiency and count memories are filled
// by load words, the others by the run.
`include "mlem_intensity_estimator_top_assert.svh"
module mlem_intensity_estimator_top #(
	parameter int MAX_SOURCES         = mlem_pkg::DEF_MAX_SOURCES,
	parameter int MAX_DETECTORS       = mlem_pkg::DEF_MAX_DETECTORS,
	parameter int INTENSITY_FRAC_BITS = mlem_pkg::DEF_FRAC_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  action,
	input  logic [7:0]  detector_index,
	input  logic [5:0]  source_index,
	input  logic [31:0] value,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [39:0] cfg_data,
	output logic        result_strobe,
	output logic [5:0]  source_number,
	output logic [39:0] intensity,
	output logic        last
);
	import mlem_pkg::*;

	localparam int SRC_W = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
	localparam int DET_W = (MAX_DETECTORS > 1) ? $clog2(MAX_DETECTORS) : 1;

	logic [9:0]  iter_count_q;
	logic [6:0]  nsrc_q;
	logic [8:0]  ndet_q;
	logic [39:0] init_q;

	logic             accept, eff_we, cnt_we;
	logic             det_ok, src_ok;
	logic [DET_W-1:0] nd_m1, rd_det;
	logic [SRC_W-1:0] ns_m1, rd_src;
	logic [23:0]      eff_rd;
	logic [31:0]      cnt_rd;
	logic [10:0]      ndet_ext;
	logic [7:0]       nsrc_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_count_q <= 10'd16;
			nsrc_q       <= 7'd64;
			ndet_q       <= 9'd256;
			init_q       <= 40'(40'd10 << INTENSITY_FRAC_BITS);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ITER: iter_count_q <= cfg_data[9:0];
				CFG_NSRC: nsrc_q       <= cfg_data[6:0];
				CFG_NDET: ndet_q       <= cfg_data[8:0];
				CFG_INIT: init_q       <= cfg_data;
				default:  init_q       <= init_q;
			endcase
		end
	end

	// Clamp active counts to one..max, held as count minus one
	assign ndet_ext = {2'd0, ndet_q};
	assign nsrc_ext = {1'b0, nsrc_q};
	always_comb begin
		if (ndet_ext == 11'd0) begin
			nd_m1 = '0;
		end else if (ndet_ext > 11'(MAX_DETECTORS)) begin
			nd_m1 = DET_W'(MAX_DETECTORS - 1);
		end else begin
			nd_m1 = DET_W'(ndet_ext - 11'd1);
		end
		if (nsrc_ext == 8'd0) begin
			ns_m1 = '0;
		end else if (nsrc_ext > 8'(MAX_SOURCES)) begin
			ns_m1 = SRC_W'(MAX_SOURCES - 1);
		end else begin
			ns_m1 = SRC_W'(nsrc_ext - 8'd1);
		end
	end

	assign accept = start && !busy;
	assign det_ok = ({24'd0, detector_index} < 32'(MAX_DETECTORS));
	assign src_ok = ({26'd0, source_index} < 32'(MAX_SOURCES));
	assign eff_we = accept && (action == ACT_EFF) && det_ok && src_ok;
	assign cnt_we = accept && (action == ACT_CNT) && det_ok;

	mlem_store #(
		.MAX_SOURCES   (MAX_SOURCES),
		.MAX_DETECTORS (MAX_DETECTORS)
	) u_store (
		.clk     (clk),
		.eff_we  (eff_we),
		.cnt_we  (cnt_we),
		.wr_det  (DET_W'(detector_index)),
		.wr_src  (SRC_W'(source_index)),
		.wr_data (value),
		.rd_det  (rd_det),
		.rd_src  (rd_src),
		.eff_rd  (eff_rd),
		.cnt_rd  (cnt_rd)
	);

	mlem_core #(
		.MAX_SOURCES         (MAX_SOURCES),
		.MAX_DETECTORS       (MAX_DETECTORS),
		.INTENSITY_FRAC_BITS (INTENSITY_FRAC_BITS)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.run           (accept && (action == ACT_RUN)),
		.nd_m1         (nd_m1),
		.ns_m1         (ns_m1),
		.iter_count    (iter_count_q),
		.init_int      (init_q),
		.eff_rd        (eff_rd),
		.cnt_rd        (cnt_rd),
		.rd_det        (rd_det),
		.rd_src        (rd_src),
		.busy          (busy),
		.res_strobe    (result_strobe),
		.res_source    (source_number),
		.res_intensity (intensity),
		.res_last      (last)
	);

	`MLEM_ASSERT_NXT(a_run_busy, clk, arst_n, accept && (action == ACT_RUN), busy)
	`MLEM_ASSERT_NXT(a_word_gap, clk, arst_n, result_strobe, !result_strobe)
	`MLEM_ASSERT_IMP(a_last_idle, clk, arst_n, result_strobe && last, !busy)
	`MLEM_ASSERT_IMP(a_mid_busy, clk, arst_n, result_strobe && !last, busy)
endmodule

// File: tb/sv/mlem_intensity_estimator_top_tb.sv
// Self-checking testbench for the MLEM intensity estimator top level
`timescale 1ns / 1ps
module mlem_intensity_estimator_top_tb;
	import mlem_pkg::*;

	localparam int NSRC = 64;
	localparam int NDET = 256;
	localparam logic [39:0] MASK40 = 40'hFF_FFFF_FFFF;
	localparam logic [63:0] ALL64 = '1;

	typedef struct packed {
		logic [1:0]  action;
		logic [7:0]  det;
		logic [5:0]  src;
		logic [31:0] value;
	} load_word_t;

	typedef struct packed {
		logic [5:0]  source_number;
		logic [39:0] intensity;
		logic        last;
	} intensity_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  action = ACT_EFF;
	logic [7:0]  detector_index = '0;
	logic [5:0]  source_index = '0;
	logic [31:0] value = '0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = CFG_ITER;
	logic [39:0] cfg_data = '0;
	logic        result_strobe;
	logic [5:0]  source_number;
	logic [39:0] intensity;
	logic        last;

	mlem_intensity_estimator_top i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .detector_index(detector_index), .source_index(source_index),
		.value(value), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.result_strobe(result_strobe), .source_number(source_number),
		.intensity(intensity), .last(last)
	);

	always #5 clk = ~clk;

	// predictor state
	logic [23:0] eff_mem [NDET*NSRC];
	logic [31:0] cnt_mem [NDET];
	logic [31:0] sens [NSRC];
	logic [39:0] lam [NSRC];
	logic [39:0] lam_next [NSRC];
	logic [63:0] ratio [NDET];
	logic [9:0]  iter_cfg = 10'd16;
	logic [6:0]  nsrc_cfg = 7'd64;
	logic [8:0]  ndet_cfg = 9'd256;
	logic [39:0] init_cfg = 40'd655360;

	// which entries the stimulus has filled so far
	bit eff_filled [NDET*NSRC];
	bit cnt_filled [NDET];

	load_word_t  pending_words[$];
	load_word_t  cur_word;
	intensity_t  expected_q[$];
	int          sender_idle = 0;
	int          fail_count = 0;
	int          runs_done = 0;
	int          loads_done = 0;
	int          results_seen = 0;

	function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? ALL64 : s[63:0];
	endfunction

	function automatic logic [63:0] sat_div(logic [127:0] n, logic [63:0] d);
		logic [127:0] q;
		if (d == 0)
			return '0;
		q = n / {64'd0, d};
		return (q[127:64] != 0) ? ALL64 : q[63:0];
	endfunction

	function automatic int clamp_count(int v, int mx);
		if (v == 0)
			return 1;
		return (v > mx) ? mx : v;
	endfunction

	function automatic void estimate_intensities();
		int ns, nd;
		logic [63:0] acc, term;
		logic [127:0] prod;
		intensity_t r;
		ns = clamp_count(int'(nsrc_cfg), NSRC);
		nd = clamp_count(int'(ndet_cfg), NDET);
		for (int j = 0; j < ns; j++) begin
			acc = 0;
			for (int i = 0; i < nd; i++)
				acc += eff_mem[i*NSRC + j];
			sens[j] = (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
			lam[j] = init_cfg;
		end
		for (int it = 0; it < int'(iter_cfg); it++) begin
			for (int i = 0; i < nd; i++) begin
				acc = 0;
				for (int j = 0; j < ns; j++)
					acc = sat_sum(acc, 64'(eff_mem[i*NSRC + j]) * 64'(lam[j]));
				ratio[i] = sat_div({64'(cnt_mem[i]) << 8, 64'd0}, acc);
			end
			for (int j = 0; j < ns; j++) begin
				acc = 0;
				for (int i = 0; i < nd; i++) begin
					prod = 128'(eff_mem[i*NSRC + j]) * 128'(ratio[i]);
					term = (prod[127:88] != 0) ? ALL64 : prod[87:24];
					acc = sat_sum(acc, term);
				end
				term = sat_div(128'(lam[j]) * 128'(acc), 64'(sens[j]) << 8);
				lam_next[j] = (term > 64'(MASK40)) ? MASK40 : term[39:0];
			end
			for (int j = 0; j < ns; j++)
				lam[j] = lam_next[j];
		end
		for (int j = 0; j < ns; j++) begin
			r = '{6'(j), lam[j], (j + 1 == ns)};
			expected_q = {expected_q, r};
		end
	endfunction

	function automatic void apply_word(load_word_t w);
		case (w.action)
			ACT_EFF: eff_mem[{w.det, w.src}] = w.value[23:0];
			ACT_CNT: cnt_mem[w.det] = w.value;
			ACT_RUN: begin
				estimate_intensities();
				runs_done++;
			end
			default: ;
		endcase
		if (w.action == ACT_EFF || w.action == ACT_CNT)
			loads_done++;
	endfunction

	// driver: present one word at a time, hold it until accepted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy)
				apply_word(cur_word);
			if (!start || !busy) begin
				if (pending_words.size() > 0 && $urandom_range(99) >= sender_idle) begin
					cur_word = pending_words.pop_front();
					start <= 1'b1;
					action <= cur_word.action;
					detector_index <= cur_word.det;
					source_index <= cur_word.src;
					value <= cur_word.value;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		intensity_t e;
		if (arst_n && result_strobe) begin
			results_seen++;
			if (expected_q.size() == 0) begin
				$error("unexpected result: source_number %0d intensity %0h", source_number,
					intensity);
				fail_count++;
			end else begin
				e = expected_q.pop_front();
				if (source_number !== e.source_number) begin
					$error("source_number: expected %0d actual %0d", e.source_number,
						source_number);
					fail_count++;
				end
				if (intensity !== e.intensity) begin
					$error("intensity: expected %0h actual %0h", e.intensity, intensity);
					fail_count++;
				end
				if (last !== e.last) begin
					$error("last: expected %0b actual %0b", e.last, last);
					fail_count++;
				end
			end
		end
	end

	task automatic push_word(logic [1:0] act, logic [7:0] det, logic [5:0] src,
		logic [31:0] val);
		load_word_t w;
		w = '{act, det, src, val};
		pending_words = {pending_words, w};
		if (act == ACT_EFF)
			eff_filled[{det, src}] = 1'b1;
		if (act == ACT_CNT)
			cnt_filled[det] = 1'b1;
	endtask

	function automatic logic [31:0] rand_value();
		case ($urandom_range(3))
			0: return $urandom_range(255);
			1: return $urandom & 32'h00FF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// fill any entry the run will read that was never written, then start the run
	task automatic push_run();
		int ns, nd;
		ns = clamp_count(int'(nsrc_cfg), NSRC);
		nd = clamp_count(int'(ndet_cfg), NDET);
		for (int i = 0; i < nd; i++) begin
			if (!cnt_filled[i])
				push_word(ACT_CNT, 8'(i), 6'd0, rand_value());
			for (int j = 0; j < ns; j++)
				if (!eff_filled[i*NSRC + j])
					push_word(ACT_EFF, 8'(i), 6'(j), $urandom);
		end
		push_word(ACT_RUN, 8'($urandom), 6'($urandom), $urandom);
	endtask

	// sample at the falling edge, once every update of the rising edge has settled
	task automatic wait_idle();
		while (pending_words.size() != 0 || start || expected_q.size() != 0 || busy)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_settings(logic [9:0] it, logic [6:0] ns, logic [8:0] nd,
		logic [39:0] init);
		wait_idle();
		@(posedge clk);
		cfg_we <= 1'b1; cfg_index <= CFG_ITER; cfg_data <= 40'(it);
		iter_cfg = it;
		@(posedge clk);
		cfg_index <= CFG_NSRC; cfg_data <= 40'(ns);
		nsrc_cfg = ns;
		@(posedge clk);
		cfg_index <= CFG_NDET; cfg_data <= 40'(nd);
		ndet_cfg = nd;
		@(posedge clk);
		cfg_index <= CFG_INIT; cfg_data <= init;
		init_cfg = init;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int ns, nd;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		sender_idle = 26;

		// saturating inputs, dropped efficiency bits, ignored action, zero iterations
		write_settings(10'd0, 7'd1, 9'd1, MASK40);
		push_word(ACT_EFF, 8'd0, 6'd0, 32'hFFFF_FFFF);
		push_word(ACT_CNT, 8'd0, 6'd0, 32'hFFFF_FFFF);
		push_word(2'd3, 8'hFF, 6'h3F, 32'hFFFF_FFFF);
		push_run();
		write_settings(10'd1, 7'd1, 9'd1, MASK40);
		push_run();
		// most iterations
		write_settings(10'd1023, 7'd1, 9'd1, 40'd655360);
		push_run();
		// source count above maximum, detector count zero
		write_settings(10'd1, 7'd127, 9'd0, 40'h1_0000);
		push_word(ACT_EFF, 8'd0, 6'd63, 32'h0000_0001);
		push_run();
		// source count zero
		write_settings(10'd1, 7'd0, 9'd3, 40'h3_0000);
		push_word(ACT_CNT, 8'd255, 6'd0, 32'd0);
		push_run();
		// zero initial intensity: every projection is zero
		write_settings(10'd3, 7'd2, 9'd2, 40'd0);
		push_run();
		// zero sensitivity on source one, zero count on detector zero
		write_settings(10'd2, 7'd2, 9'd2, 40'd655360);
		push_word(ACT_EFF, 8'd0, 6'd1, 32'hFF00_0000);
		push_word(ACT_EFF, 8'd1, 6'd1, 32'd0);
		push_word(ACT_CNT, 8'd0, 6'd0, 32'd0);
		push_run();
		write_settings(10'd2, 7'd64, 9'd1, 40'd655360);
		push_run();

		// random batches over three idling phases
		for (int b = 0; b < 21; b++) begin
			sender_idle = (b < 7) ? 26 : (b < 14) ? 68 : 0;
			write_settings(10'($urandom_range(6)), 7'($urandom_range(8)),
				9'($urandom_range(8)), {8'($urandom_range(255) >> $urandom_range(8)), $urandom});
			ns = clamp_count(int'(nsrc_cfg), NSRC);
			nd = clamp_count(int'(ndet_cfg), NDET);
			for (int k = 0; k < 14; k++) begin
				case ($urandom_range(9))
					0: push_word(ACT_EFF, 8'($urandom), 6'($urandom), $urandom);
					1: push_word(ACT_CNT, 8'($urandom), 6'($urandom), $urandom);
					2: push_word(2'd3, 8'($urandom), 6'($urandom), $urandom);
					3, 4: push_word(ACT_CNT, 8'($urandom_range(nd - 1)), 6'($urandom),
						rand_value());
					default: push_word(ACT_EFF, 8'($urandom_range(nd - 1)),
						6'($urandom_range(ns - 1)), $urandom);
				endcase
			end
			push_run();
		end

		wait_idle();
		$display("covered %0d load words and %0d runs, %0d intensities checked",
			loads_done, runs_done, results_seen);
		if (fail_count == 0)
			$display("mlem_intensity_estimator_top_tb: PASS");
		else
			$display("mlem_intensity_estimator_top_tb: FAIL");
		$finish;
	end

	initial begin
		#50ms;
		$display("timeout waiting for the estimator to finish");
		$display("mlem_intensity_estimator_top_tb: FAIL");
		$finish;
	end
endmodule
